>>> rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked assertion helpers shared by the RTL; ASSERT_OFF removes them.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

`define ASSERT_NEVER(label, clk, rst, expr) \
   `ASSERT_CLK(label, clk, rst, !(expr))

`else

`define ASSERT_CLK(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, expr)

`endif

`endif

>>> rtl/dsrm_pkg.sv
// ---------------------------------------------------------------------------
// Dot-star matcher package
// Pattern constants, register indexes and the structs that reach each cell.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dsrm_pkg;

   localparam int PAT_CHARS = 16;

   localparam logic [7:0] CHAR_ANY  = 8'h2E;
   localparam logic [7:0] CHAR_STAR = 8'h2A;

   localparam logic [1:0] CSR_CHARS_LOW  = 2'd0;
   localparam logic [1:0] CSR_CHARS_HIGH = 2'd1;
   localparam logic [1:0] CSR_LENGTH     = 2'd2;

   typedef struct packed {
      logic [7:0] pchar;
      logic       starred;
      logic       below_len;
      logic       in_range;
      logic       at_len;
   } cell_cfg_type;

   typedef struct packed {
      logic accept;
      logic char_valid;
      logic restart;
   } cell_step_type;

endpackage

`default_nettype wire

>>> rtl/dot_star_regex_matcher.sv
// ---------------------------------------------------------------------------
// Dot-star regular expression matcher
// Whole-string match of a streamed text against a '.' and 'x*' pattern.
// ---------------------------------------------------------------------------
// The text enters on the req_ stream, one character per transfer, and every
// transfer yields exactly one rsp_ transfer that tells whether the text so
// far matches the whole pattern. req_tuser set means req_tdata holds a
// character; clear means an item without a character. req_tlast ends the
// text, and its result carries rsp_tlast; the next transfer starts a new text.
// The pattern and its length are to be written on the csr_ port only while
// idle; the block does not enforce this. A row of cells, one per pattern
// position, holds the active set; the star closure ripples along the row.
// One cell stage updates the set, a second closes it again for the answer,
// then the output register. The block takes one transfer per cycle unless
// the output stalls: when rsp_tready is low the output register holds and
// req_tready drops once the internal stage is also full. Reset clears the
// pattern and the length, empties the pipeline and leaves only position
// zero active.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module dot_star_regex_matcher
   import dsrm_pkg::*;
#(
   parameter int PATTERN_LEN = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_addr,
   input  wire logic [63:0] csr_wdata,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] text_char
   input  wire logic        req_tuser,   // [0] char_valid
   input  wire logic        req_tlast,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // [0] full_match, [7:1] zero
   output logic             rsp_tlast
);

   localparam int LW = $clog2(PATTERN_LEN + 1);

   logic [63:0]         chars_low_ff;
   logic [63:0]         chars_high_ff;
   logic [4:0]          len_ff;
   logic [127:0]        pattern_chars;
   logic [LW-1:0]       eff_len;

   logic                mid_valid_ff, mid_valid_in;
   logic                mid_last_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_match_ff, rsp_last_ff;
   logic                advance, req_fire;
   cell_step_type       step;

   logic [PATTERN_LEN:0] carry_a, carry_b, adv, match_vec, active_vec, at_len_vec;

   always_ff @(posedge clock) begin
      if (reset) begin
         chars_low_ff  <= '0;
         chars_high_ff <= '0;
         len_ff        <= '0;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_CHARS_LOW:  chars_low_ff  <= csr_wdata;
            CSR_CHARS_HIGH: chars_high_ff <= csr_wdata;
            CSR_LENGTH:     len_ff        <= csr_wdata[4:0];
            default:        ;
         endcase
      end
   end

   assign pattern_chars = {chars_high_ff, chars_low_ff};

   always_comb begin
      if (32'(len_ff) > PATTERN_LEN) begin
         eff_len = LW'(PATTERN_LEN);
      end else begin
         eff_len = LW'(len_ff);
      end
   end

   assign advance      = !rsp_valid_ff || rsp_tready;
   assign req_tready   = !mid_valid_ff || advance;
   assign req_fire     = req_tvalid && req_tready;
   assign mid_valid_in = req_fire ? 1'b1 : (advance ? 1'b0 : mid_valid_ff);
   assign rsp_valid_in = advance ? mid_valid_ff : rsp_valid_ff;

   assign step = '{accept: req_fire, char_valid: req_tuser, restart: req_tlast};

   for (genvar j = 0; j <= PATTERN_LEN; j++) begin : g_cell
      logic [7:0]   pc;
      logic         star_next;
      cell_cfg_type cell_cfg;

      if (j < PAT_CHARS) begin : g_char
         assign pc = pattern_chars[8*j +: 8];
      end else begin : g_nochar
         assign pc = '0;
      end

      if ((j + 1 < PAT_CHARS) && (j < PATTERN_LEN)) begin : g_star
         assign star_next = (pattern_chars[8*(j+1) +: 8] == CHAR_STAR) &&
                            (LW'(j + 1) < eff_len);
      end else begin : g_nostar
         assign star_next = 1'b0;
      end

      assign at_len_vec[j] = (eff_len == LW'(j));
      assign cell_cfg = '{pchar: pc, starred: star_next,
                          below_len: (LW'(j) < eff_len),
                          in_range: (LW'(j) <= eff_len),
                          at_len: at_len_vec[j]};

      dsrm_cell #(
         .ORIGIN (j == 0)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .cfg         (cell_cfg),
         .step        (step),
         .text_char   (req_tdata),
         .carry_a_in  ((j >= 2) ? carry_a[(j >= 2) ? j - 2 : 0] : 1'b0),
         .carry_b_in  ((j >= 2) ? carry_b[(j >= 2) ? j - 2 : 0] : 1'b0),
         .adv_in      ((j >= 1) ? adv[(j >= 1) ? j - 1 : 0] : 1'b0),
         .carry_a_out (carry_a[j]),
         .carry_b_out (carry_b[j]),
         .adv_out     (adv[j]),
         .match_out   (match_vec[j]),
         .state_out   (active_vec[j])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mid_valid_ff <= mid_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         mid_last_ff <= req_tlast;
      end
      if (advance) begin
         rsp_match_ff <= |match_vec;
         rsp_last_ff  <= mid_last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_match_ff};
   assign rsp_tlast  = rsp_last_ff;

   `ASSERT_CLK(a_fire_fills_mid, clock, reset, req_fire |=> mid_valid_ff)
   `ASSERT_CLK(a_end_restarts, clock, reset,
      (req_fire && req_tlast) |=> (active_vec == (PATTERN_LEN+1)'(1)))
   `ASSERT_CLK(a_empty_item_holds, clock, reset,
      (req_fire && !req_tuser && !req_tlast) |=> $stable(active_vec))
   `ASSERT_CLK(a_one_length_cell, clock, reset, $onehot(at_len_vec))

endmodule

`default_nettype wire

>>> rtl/dsrm_cell.sv
// ---------------------------------------------------------------------------
// Dot-star matcher cell
// Holds one pattern position of the active set and of the internal stage.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dsrm_cell
   import dsrm_pkg::*;
#(
   parameter bit ORIGIN = 1'b0
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire cell_cfg_type  cfg,
   input  wire cell_step_type step,
   input  wire logic [7:0]    text_char,
   input  wire logic          carry_a_in,
   input  wire logic          carry_b_in,
   input  wire logic          adv_in,
   output logic               carry_a_out,
   output logic               carry_b_out,
   output logic               adv_out,
   output logic               match_out,
   output logic               state_out
);

   logic active_ff, active_in;
   logic post_ff, post_in;
   logic closed_a, closed_b, hit, next_pos;

   always_comb begin
      closed_a    = (active_ff & cfg.in_range) | carry_a_in;
      carry_a_out = closed_a & cfg.starred;
      hit         = cfg.below_len & ((cfg.pchar == CHAR_ANY) || (cfg.pchar == text_char));
      adv_out     = closed_a & hit & ~cfg.starred;
      next_pos    = (closed_a & hit & cfg.starred) | adv_in;
      post_in     = step.char_valid ? next_pos : active_ff;
      active_in   = step.restart ? ORIGIN : post_in;

      closed_b    = (post_ff & cfg.in_range) | carry_b_in;
      carry_b_out = closed_b & cfg.starred;
      match_out   = closed_b & cfg.at_len;
      state_out   = active_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= ORIGIN;
      end else if (step.accept) begin
         active_ff <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step.accept) begin
         post_ff <= post_in;
      end
   end

endmodule

`default_nettype wire

>>> dv/dot_star_regex_matcher_tb.sv
// ---------------------------------------------------------------------------
// Dot-star regular expression matcher testbench
// Streams texts against patterns written on the csr_ port and checks every
// rsp_ transfer against a position-set predictor kept in a scoreboard.
// A short directed part covers the corner cases, then random patterns and
// texts run under several idling phases, including one long output stall.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module dot_star_regex_matcher_tb;
   import dsrm_pkg::*;

   localparam int ITEMS = 1050;
   localparam logic [7:0] CH_A = 8'h61;
   localparam logic [7:0] CH_B = 8'h62;
   localparam logic [7:0] CH_C = 8'h63;

   typedef struct packed {
      logic full_match;
      logic end_of_text;
   } match_result_type;

   class match_scoreboard;
      logic [63:0]         chars_low;
      logic [63:0]         chars_high;
      logic [4:0]          length_reg;
      logic [PAT_CHARS:0]  active;
      match_result_type    expected_matches[$];
      int                  errors;

      function new();
         chars_low  = '0;
         chars_high = '0;
         length_reg = '0;
         active     = {{PAT_CHARS{1'b0}}, 1'b1};
         errors     = 0;
      endfunction

      function void write_reg(logic [1:0] idx, logic [63:0] value);
         case (idx)
            CSR_CHARS_LOW:  chars_low  = value;
            CSR_CHARS_HIGH: chars_high = value;
            CSR_LENGTH:     length_reg = value[4:0];
            default: ;
         endcase
      endfunction

      function logic [7:0] pattern_byte(int k);
         if (k < 8)
            return chars_low[8*k +: 8];
         if (k < 16)
            return chars_high[8*(k-8) +: 8];
         return 8'h00;
      endfunction

      function int span();
         return (length_reg > PAT_CHARS) ? PAT_CHARS : int'(length_reg);
      endfunction

      function bit is_starred(int j, int len);
         return (j + 1 < len) && (pattern_byte(j + 1) == CHAR_STAR);
      endfunction

      function logic [PAT_CHARS:0] close_over_stars(logic [PAT_CHARS:0] s, int len);
         logic [PAT_CHARS:0] d;
         d = '0;
         for (int j = 0; j <= len; j++)
            d[j] = s[j];
         for (int j = 0; j < len; j++)
            if (d[j] && is_starred(j, len))
               d[j+2] = 1'b1;
         return d;
      endfunction

      function void note_text_item(logic [7:0] c, logic has_char, logic last);
         logic [PAT_CHARS:0] closed;
         logic [PAT_CHARS:0] advanced;
         logic [7:0]         pc;
         match_result_type   res;
         int                 len;
         len    = span();
         closed = close_over_stars(active, len);
         if (has_char) begin
            advanced = '0;
            for (int j = 0; j < len; j++) begin
               pc = pattern_byte(j);
               if (closed[j] && (pc == CHAR_ANY || pc == c)) begin
                  if (is_starred(j, len))
                     advanced[j] = 1'b1;
                  else
                     advanced[j+1] = 1'b1;
               end
            end
            active = advanced;
            closed = close_over_stars(active, len);
         end
         res.full_match  = closed[len];
         res.end_of_text = last;
         expected_matches.push_back(res);
         if (last)
            active = {{PAT_CHARS{1'b0}}, 1'b1};
      endfunction

      function void check_match(logic [7:0] data, logic last);
         match_result_type exp_res;
         if (expected_matches.size() == 0) begin
            $display("%0t: unexpected result, expected none, got tdata %h tlast %b",
                     $time, data, last);
            errors++;
            return;
         end
         exp_res = expected_matches.pop_front();
         if (data != {7'd0, exp_res.full_match}) begin
            $display("%0t: full_match mismatch, expected tdata %h, got %h",
                     $time, {7'd0, exp_res.full_match}, data);
            errors++;
         end
         if (last != exp_res.end_of_text) begin
            $display("%0t: end_of_text mismatch, expected %b, got %b",
                     $time, exp_res.end_of_text, last);
            errors++;
         end
      endfunction

      function int pending();
         return expected_matches.size();
      endfunction
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        csr_we     = 1'b0;
   logic [1:0]  csr_addr   = CSR_CHARS_LOW;
   logic [63:0] csr_wdata  = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;   // [7:0] text_char
   logic        req_tuser  = 1'b0; // [0] char_valid
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;         // [0] full_match, [7:1] zero
   logic        rsp_tlast;

   match_scoreboard sb = new();

   int          send_idle_pct  = 0;
   int          recv_stall_pct = 0;
   int          sent_items     = 0;
   bit          hold_req       = 0;
   bit          hold_done      = 0;
   int          hold_left      = 0;
   logic [7:0]  pat_bytes[PAT_CHARS];
   int          pat_span       = 0;

   dot_star_regex_matcher DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_we)
            sb.write_reg(csr_addr, csr_wdata);
         if (req_tvalid && req_tready)
            sb.note_text_item(req_tdata, req_tuser, req_tlast);
         if (rsp_tvalid && rsp_tready)
            sb.check_match(rsp_tdata, rsp_tlast);
      end
   end

   // The long hold-off is counted here so that the sender keeps offering.
   always @(posedge clock) begin
      if (hold_req) begin
         hold_left = 300;
         hold_req  = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   function automatic logic [127:0] pack_text(string s);
      logic [127:0] r;
      r = '0;
      for (int k = 0; k < s.len(); k++)
         r[8*k +: 8] = s[k];
      return r;
   endfunction

   function automatic logic [7:0] fill_char();
      int r;
      r = $urandom_range(99);
      if (r < 22)
         return CH_A;
      if (r < 44)
         return CH_B;
      if (r < 60)
         return CH_C;
      if (r < 68)
         return CHAR_ANY;
      if (r < 76)
         return CHAR_STAR;
      return 8'($urandom_range(255));
   endfunction

   task automatic send_item(input logic [7:0] c, input logic has_char, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tuser  <= has_char;
      req_tlast  <= last;
      do begin
         @(posedge clock);
      end while (!req_tready);
      sent_items++;
   endtask

   // The first edge makes sure the last transfer has reached the scoreboard.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic load_pattern(input logic [63:0] low, input logic [63:0] high,
                               input logic [63:0] len_word);
      csr_we    <= 1'b1;
      csr_addr  <= CSR_CHARS_LOW;
      csr_wdata <= low;
      @(posedge clock);
      csr_addr  <= CSR_CHARS_HIGH;
      csr_wdata <= high;
      @(posedge clock);
      csr_addr  <= CSR_LENGTH;
      csr_wdata <= len_word;
      @(posedge clock);
      csr_we    <= 1'b0;
      for (int k = 0; k < PAT_CHARS; k++)
         pat_bytes[k] = (k < 8) ? low[8*k +: 8] : high[8*(k-8) +: 8];
      pat_span = (len_word[4:0] > PAT_CHARS) ? PAT_CHARS : int'(len_word[4:0]);
   endtask

   task automatic new_pattern();
      logic [127:0] p;
      logic [63:0]  len_word;
      int           r;
      int           n;
      for (int k = 0; k < PAT_CHARS; k++) begin
         r = $urandom_range(99);
         if (r < 45)
            p[8*k +: 8] = CH_A + 8'($urandom_range(2));
         else if (r < 62)
            p[8*k +: 8] = CHAR_ANY;
         else if (r < 90)
            p[8*k +: 8] = CHAR_STAR;
         else
            p[8*k +: 8] = 8'($urandom_range(255));
      end
      r = $urandom_range(9);
      if (r == 0)
         n = 0;
      else if (r == 1)
         n = PAT_CHARS;
      else if (r == 2)
         n = $urandom_range(31, PAT_CHARS + 1);
      else
         n = $urandom_range(PAT_CHARS - 1, 1);
      len_word = 64'(n);
      if ($urandom_range(3) == 0)
         len_word = ({$urandom, $urandom} & ~64'h1F) | 64'(n);
      load_pattern(p[63:0], p[127:64], len_word);
   endtask

   task automatic send_text();
      logic [7:0] txt[$];
      logic [7:0] c;
      int         k;
      int         n;
      int         pos;
      int         end_kind;
      k = 0;
      while (k < pat_span) begin
         c = pat_bytes[k];
         if (k + 1 < pat_span && pat_bytes[k+1] == CHAR_STAR) begin
            n = $urandom_range(3);
            repeat (n) txt.push_back((c == CHAR_ANY) ? fill_char() : c);
            k += 2;
         end else begin
            txt.push_back((c == CHAR_ANY) ? fill_char() : c);
            k++;
         end
      end
      if ($urandom_range(99) < 35) begin
         pos = (txt.size() == 0) ? 0 : $urandom_range(txt.size() - 1);
         case ($urandom_range(2))
            0: if (txt.size() != 0) txt[pos] = fill_char();
            1: if (txt.size() != 0) txt.delete(pos);
            default: txt.insert(pos, fill_char());
         endcase
      end
      if ($urandom_range(99) < 6) begin
         txt.delete();
         repeat ($urandom_range(6)) txt.push_back(8'($urandom_range(255)));
      end
      // Below 12 ends on a marker without a character, 12 to 15 leaves the
      // text open, the rest ends on the last character.
      end_kind = $urandom_range(99);
      if (txt.size() == 0)
         end_kind = 0;
      foreach (txt[i]) begin
         if ($urandom_range(99) < 8)
            send_item(8'($urandom_range(255)), 1'b0, 1'b0);
         send_item(txt[i], 1'b1, end_kind >= 16 && i == txt.size() - 1);
      end
      if (end_kind < 12)
         send_item(8'($urandom_range(255)), 1'b0, 1'b1);
   endtask

   initial begin
      logic [127:0] p;
      int           phase;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Empty pattern after reset.
      send_item(8'hA5, 1'b0, 1'b1);
      send_item(8'hFF, 1'b1, 1'b1);
      drain();

      // Leading stray star, a starred literal, a wildcard and a trailing stray star.
      p = pack_text("*a*.b**");
      load_pattern(p[63:0], p[127:64], 64'd7);
      send_item("*", 1'b1, 1'b0);
      send_item(8'h00, 1'b0, 1'b0);
      send_item("a", 1'b1, 1'b0);
      send_item("a", 1'b1, 1'b0);
      send_item("x", 1'b1, 1'b0);
      send_item("b", 1'b1, 1'b0);
      send_item("*", 1'b1, 1'b1);
      send_item("*", 1'b1, 1'b0);
      send_item(".", 1'b1, 1'b0);
      send_item("*", 1'b1, 1'b1);
      drain();

      // A dot in the text is a plain byte.
      p = pack_text("ab");
      load_pattern(p[63:0], p[127:64], 64'd2);
      send_item(".", 1'b1, 1'b0);
      send_item("b", 1'b1, 1'b1);
      // Pattern change in the middle of a text.
      send_item("a", 1'b1, 1'b0);
      drain();
      p = pack_text("a.c");
      load_pattern(p[63:0], p[127:64], 64'd3);
      send_item("x", 1'b1, 1'b0);
      send_item("c", 1'b1, 1'b1);
      drain();

      // Length above the pattern size, with extreme pattern bytes.
      p = pack_text("xxxxa*a*a*a*a*a*");
      p[7:0]   = 8'hFF;
      p[15:8]  = CHAR_STAR;
      p[23:16] = 8'h00;
      p[31:24] = CHAR_STAR;
      load_pattern(p[63:0], p[127:64], 64'hFFFF_FFFF_FFFF_FFF4);
      send_item(8'hFF, 1'b1, 1'b0);
      send_item(8'hFF, 1'b1, 1'b0);
      send_item(8'h00, 1'b1, 1'b0);
      send_item("a", 1'b1, 1'b1);
      send_item(8'h80, 1'b1, 1'b1);
      send_item(8'h3C, 1'b0, 1'b1);

      sent_items = 0;
      while (sent_items < ITEMS) begin
         phase = sent_items * 4 / ITEMS;
         if (phase > 3)
            phase = 3;
         drain();
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
            default: begin send_idle_pct = 24; recv_stall_pct = 24; end
         endcase
         new_pattern();
         if (phase == 0 && !hold_done && sent_items > 60) begin
            hold_req  = 1;
            hold_done = 1;
         end
         repeat ($urandom_range(7, 3)) send_text();
      end
      drain();

      if (sb.errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
